// ===== rtl/i2c_master_bit_phase_engine_macros.svh =====
// Assertion macros for the I2C master bit phase engine.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef I2C_MASTER_BIT_PHASE_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_PHASE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CBPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cbpe_pkg.sv =====
// Shared types and constants for the I2C master bit phase engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package i2cbpe_pkg;

    localparam int PHASE_W = 5;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_TX_ACK = 3'd4,
        CMD_RX_ACK = 3'd5
    } cmd_t;

    // Index of the final phase of the start, write and read commands.
    localparam logic [PHASE_W-1:0] START_LAST = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] WRITE_LAST = PHASE_W'(23);
    localparam logic [PHASE_W-1:0] READ_LAST  = PHASE_W'(16);

    typedef enum logic {
        PIN_SCL = 1'b0,
        PIN_SDA = 1'b1
    } pin_t;

    typedef enum logic [1:0] {
        VAL_ZERO = 2'd0,
        VAL_ONE  = 2'd1,
        VAL_TX   = 2'd2,
        VAL_ACK  = 2'd3
    } val_t;

    typedef struct packed {
        logic load;
        logic step;
        pin_t pin;
        val_t val;
        logic last;
        logic rpt_rx;
        logic rpt_ack;
    } dp_ctl_t;

    typedef struct packed {
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/i2cbpe_cmd_if.sv =====
// Command channel of the I2C master bit phase engine.
// Carries one command word with its handshake; no dependencies.
`default_nettype none

interface i2cbpe_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] bus_levels;

    modport source (output valid, output cmd, output tx_byte, output ack_out,
                    output bus_levels, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input ack_out,
                    input bus_levels, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbpe_phase_if.sv =====
// Phase channel of the I2C master bit phase engine.
// Carries one pin write word with its handshake; no dependencies.
`default_nettype none

interface i2cbpe_phase_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       last;

    modport source (output valid, output scl, output sda, output rx_byte,
                    output ack_in, output last, input ready);
    modport sink   (input valid, input scl, input sda, input rx_byte,
                    input ack_in, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbpe_ctrl.sv =====
// Sequencer of the I2C master bit phase engine: steps through the phases
// of one command. Depends on i2cbpe_pkg.
`default_nettype none

module i2cbpe_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           cmd,
    input  wire i2cbpe_pkg::dp_stat_t stat,
    output i2cbpe_pkg::dp_ctl_t       ctl
);
    import i2cbpe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [1:0]           sub_reg, sub_next;
    logic                 accept;
    logic                 known;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign known    = (cmd <= CMD_RX_ACK);

    // Phase decode: which pin is written, with what, and whether it ends the command.
    always_comb
    begin
        ctl.load    = accept;
        ctl.step    = 1'b0;
        ctl.pin     = PIN_SCL;
        ctl.val     = VAL_ZERO;
        ctl.last    = 1'b0;
        ctl.rpt_rx  = 1'b0;
        ctl.rpt_ack = 1'b0;
        unique case (cmd_reg)
            CMD_START:
            begin
                unique case (phase_reg[1:0])
                    2'd0:
                    begin
                        ctl.pin = PIN_SDA;
                        ctl.val = VAL_ONE;
                    end
                    2'd1:
                    begin
                        ctl.val = VAL_ONE;
                    end
                    2'd2:
                    begin
                        ctl.pin = PIN_SDA;
                    end
                    default:
                    begin
                        ctl.last = (phase_reg == START_LAST);
                    end
                endcase
            end
            CMD_STOP:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        ctl.pin = PIN_SDA;
                    end
                    2'd1:
                    begin
                        ctl.val = VAL_ONE;
                    end
                    default:
                    begin
                        ctl.pin  = PIN_SDA;
                        ctl.val  = VAL_ONE;
                        ctl.last = 1'b1;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        ctl.pin = PIN_SDA;
                        ctl.val = VAL_TX;
                    end
                    2'd1:
                    begin
                        ctl.val = VAL_ONE;
                    end
                    default:
                    begin
                        ctl.last = (phase_reg == WRITE_LAST);
                    end
                endcase
            end
            CMD_READ:
            begin
                if (phase_reg == '0)
                begin
                    ctl.pin = PIN_SDA;
                    ctl.val = VAL_ONE;
                end
                else if (phase_reg[0])
                begin
                    ctl.val = VAL_ONE;
                end
                else
                begin
                    ctl.last   = (phase_reg == READ_LAST);
                    ctl.rpt_rx = ctl.last;
                end
            end
            CMD_TX_ACK:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        ctl.pin = PIN_SDA;
                        ctl.val = VAL_ACK;
                    end
                    2'd1:
                    begin
                        ctl.val = VAL_ONE;
                    end
                    default:
                    begin
                        ctl.last = 1'b1;
                    end
                endcase
            end
            CMD_RX_ACK:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        ctl.pin = PIN_SDA;
                        ctl.val = VAL_ONE;
                    end
                    2'd1:
                    begin
                        ctl.val = VAL_ONE;
                    end
                    default:
                    begin
                        ctl.last    = 1'b1;
                        ctl.rpt_ack = 1'b1;
                    end
                endcase
            end
            default:
            begin
                ctl.last = 1'b1;
            end
        endcase
        ctl.step = (state_reg == ST_RUN) && stat.slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // An unknown command is taken and dropped without any phase.
                if (accept && known)
                begin
                    state_next = ST_RUN;
                    cmd_next   = cmd_t'(cmd);
                    phase_next = '0;
                    sub_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (ctl.step)
                begin
                    if (ctl.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg + PHASE_W'(1);
                        sub_next   = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_START;
            phase_reg <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2cbpe_dp.sv =====
// Datapath of the I2C master bit phase engine: pin levels, data shift
// register and the output word register. Depends on i2cbpe_pkg and i2cbpe_phase_if.
`default_nettype none

module i2cbpe_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          tx_byte,
    input  wire logic                ack_out,
    input  wire logic [7:0]          bus_levels,
    input  wire i2cbpe_pkg::dp_ctl_t ctl,
    output i2cbpe_pkg::dp_stat_t     stat,
    i2cbpe_phase_if.source           phase
);
    import i2cbpe_pkg::*;

    logic       scl_level_reg, scl_level_next;
    logic       sda_level_reg, sda_level_next;
    logic [7:0] tx_reg, tx_next;
    logic       ack_reg;
    logic [7:0] lv_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_scl_reg, out_sda_reg, out_ack_reg, out_last_reg;
    logic [7:0] out_rx_reg;
    logic       pin_val;

    assign stat.slot_free = !out_valid_reg || phase.ready;

    always_comb
    begin
        unique case (ctl.val)
            VAL_ZERO: pin_val = 1'b0;
            VAL_ONE:  pin_val = 1'b1;
            VAL_TX:   pin_val = tx_reg[7];
            VAL_ACK:  pin_val = ack_reg;
            default:  pin_val = 1'b1;
        endcase
    end

    always_comb
    begin
        scl_level_next = scl_level_reg;
        sda_level_next = sda_level_reg;
        tx_next        = tx_reg;
        if (ctl.load)
        begin
            tx_next = tx_byte;
        end
        if (ctl.step)
        begin
            if (ctl.pin == PIN_SCL)
            begin
                scl_level_next = pin_val;
            end
            else
            begin
                sda_level_next = pin_val;
            end
            // The data bits go out MSB first, one per SDA write.
            if (ctl.val == VAL_TX)
            begin
                tx_next = {tx_reg[6:0], 1'b0};
            end
        end
        if (ctl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (phase.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_level_reg <= 1'b1;
            sda_level_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scl_level_reg <= scl_level_next;
            sda_level_reg <= sda_level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg <= tx_next;
        if (ctl.load)
        begin
            ack_reg <= ack_out;
            lv_reg  <= bus_levels;
        end
        if (ctl.step)
        begin
            out_scl_reg  <= scl_level_next;
            out_sda_reg  <= sda_level_next;
            out_rx_reg   <= ctl.rpt_rx ? lv_reg : 8'h00;
            out_ack_reg  <= ctl.rpt_ack && lv_reg[0];
            out_last_reg <= ctl.last;
        end
    end

    assign phase.valid   = out_valid_reg;
    assign phase.scl     = out_scl_reg;
    assign phase.sda     = out_sda_reg;
    assign phase.rx_byte = out_rx_reg;
    assign phase.ack_in  = out_ack_reg;
    assign phase.last    = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_phase_engine.sv =====
// I2C master bit phase engine, top level: sequencer plus datapath.
// Depends on i2cbpe_pkg, both channel interfaces, i2cbpe_ctrl, i2cbpe_dp and the macros header.
//
// Takes one bus command word (start, stop, write byte, read byte, send ack,
// receive ack) and emits, one word per cycle while the sink keeps ready high,
// the SCL/SDA pin writes of that command: 4 for start, 3 for stop, 24 for
// write byte, 17 for read byte and 3 for either acknowledge. The sequencer
// issues one phase per cycle, while the single output register is free or
// being taken, into that register; a command is accepted in the cycle after
// the previous command's final phase has been issued. Commands 6 and 7 are
// accepted and dropped without any pin write. The pin levels start released
// high after reset and carry over between commands; the received byte and
// the acknowledge bit appear on the final word only.
`default_nettype none

`include "i2c_master_bit_phase_engine_macros.svh"

module i2c_master_bit_phase_engine (
    input  wire logic      clk,
    input  wire logic      rst_n,
    i2cbpe_cmd_if.sink     cmd_ch,
    i2cbpe_phase_if.source phase_ch
);
    import i2cbpe_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    i2cbpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .cmd      (cmd_ch.cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    i2cbpe_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tx_byte    (cmd_ch.tx_byte),
        .ack_out    (cmd_ch.ack_out),
        .bus_levels (cmd_ch.bus_levels),
        .ctl        (ctl),
        .stat       (stat),
        .phase      (phase_ch)
    );

    `I2CBPE_ASSERT_NEXT(a_busy_after_cmd, cmd_ch.valid && cmd_ch.ready && (cmd_ch.cmd <= CMD_RX_ACK), !cmd_ch.ready, "known command did not start a sequence")
    `I2CBPE_ASSERT_NOW(a_rx_only_last, phase_ch.valid && !phase_ch.last, (phase_ch.rx_byte == 8'h00) && !phase_ch.ack_in, "received data shown before final phase")
    `I2CBPE_ASSERT_NOW(a_ack_scl_low, phase_ch.valid && phase_ch.ack_in, phase_ch.last && !phase_ch.scl, "acknowledge reported outside SCL low final phase")
    `I2CBPE_ASSERT_NOW(a_step_slot, ctl.step, !phase_ch.valid || phase_ch.ready, "phase issued over an untaken word")

endmodule

`default_nettype wire
